[hdl/rwcc_pkg.sv]
// Shared types and constants for the route window and capacity checker.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package rwcc_pkg;

  // Field widths
  localparam int DIST_W     = 20;
  localparam int SECS_W     = 16;
  localparam int TIME_W     = 24;
  localparam int LOAD_W     = 16;
  localparam int SUM_W      = 32;
  localparam int CAP_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_CAP = 4'd0,
    CFG_VOLUME_CAP = 4'd1
  } cfg_reg_t;

  // Classified leg as handed from front to back. On a return leg the front
  // has already neutralized the window and the load so the back needs no branch.
  typedef struct packed {
    logic [DIST_W-1:0] leg_distance;
    logic [SECS_W-1:0] leg_seconds;
    logic [TIME_W-1:0] window_start;
    logic [TIME_W-1:0] window_end;
    logic [LOAD_W-1:0] parcel_weight;
    logic [LOAD_W-1:0] parcel_volume;
    logic              is_return;
  } leg_cmd_t;

  // One result item
  typedef struct packed {
    logic [TIME_W-1:0] stop_time;
    logic              route_done;
    logic              feasible;
    logic              capacity_ok;
    logic              windows_ok;
    logic [SUM_W-1:0]  total_distance;
    logic [SUM_W-1:0]  total_seconds;
    logic [CAP_W-1:0]  weight_total;
    logic [CAP_W-1:0]  volume_total;
  } result_t;

  // Handshake between front and queue, and between queue and back
  typedef struct packed {
    logic     valid;
    leg_cmd_t cmd;
  } cmd_xfer_t;

endpackage

[hdl/rwcc_if.sv]
// Channel interfaces of the route window and capacity checker: leg input,
// result output and configuration write. Depends on rwcc_pkg.

interface rwcc_leg_if;
  logic                           valid;
  logic                           ready;
  logic [rwcc_pkg::DIST_W-1:0]    leg_distance;
  logic [rwcc_pkg::SECS_W-1:0]    leg_seconds;
  logic [rwcc_pkg::TIME_W-1:0]    window_start;
  logic [rwcc_pkg::TIME_W-1:0]    window_end;
  logic [rwcc_pkg::LOAD_W-1:0]    parcel_weight;
  logic [rwcc_pkg::LOAD_W-1:0]    parcel_volume;
  logic                           is_return;

  modport source (output valid, leg_distance, leg_seconds, window_start, window_end,
                  parcel_weight, parcel_volume, is_return, input ready);
  modport sink   (input valid, leg_distance, leg_seconds, window_start, window_end,
                  parcel_weight, parcel_volume, is_return, output ready);
endinterface

interface rwcc_res_if;
  logic                           valid;
  logic                           ready;
  logic [rwcc_pkg::TIME_W-1:0]    stop_time;
  logic                           route_done;
  logic                           feasible;
  logic                           capacity_ok;
  logic                           windows_ok;
  logic [rwcc_pkg::SUM_W-1:0]     total_distance;
  logic [rwcc_pkg::SUM_W-1:0]     total_seconds;
  logic [rwcc_pkg::CAP_W-1:0]     weight_total;
  logic [rwcc_pkg::CAP_W-1:0]     volume_total;

  modport source (output valid, stop_time, route_done, feasible, capacity_ok, windows_ok,
                  total_distance, total_seconds, weight_total, volume_total, input ready);
  modport sink   (input valid, stop_time, route_done, feasible, capacity_ok, windows_ok,
                  total_distance, total_seconds, weight_total, volume_total, output ready);
endinterface

interface rwcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rwcc_pkg::CFG_IDX_W-1:0]    index;
  logic [rwcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/rwcc_front.sv]
// Front stage: accepts legs, classifies delivery against return legs and
// registers the classified command. Depends on rwcc_pkg and rwcc_if.

module rwcc_front (
  input  logic                clk,
  input  logic                rst,
  rwcc_leg_if.sink            leg,
  output rwcc_pkg::cmd_xfer_t push,
  input  logic                push_ready
);

  logic               cmd_valid;
  rwcc_pkg::leg_cmd_t cmd;
  rwcc_pkg::leg_cmd_t cmd_next;
  logic               take;

  // Take a new leg whenever the stage is empty or drains into the queue
  assign leg.ready = !cmd_valid || push_ready;
  assign take      = leg.valid && leg.ready;

  // Classify: a return leg gets an open window and no load
  always_comb begin
    cmd_next.leg_distance  = leg.leg_distance;
    cmd_next.leg_seconds   = leg.leg_seconds;
    cmd_next.is_return     = leg.is_return;
    if (leg.is_return) begin
      cmd_next.window_start  = '0;
      cmd_next.window_end    = '1;
      cmd_next.parcel_weight = '0;
      cmd_next.parcel_volume = '0;
    end else begin
      cmd_next.window_start  = leg.window_start;
      cmd_next.window_end    = leg.window_end;
      cmd_next.parcel_weight = leg.parcel_weight;
      cmd_next.parcel_volume = leg.parcel_volume;
    end
  end

  // Hold valid until the queue takes the command
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (push_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_next;
    end
  end

  assign push.valid = cmd_valid;
  assign push.cmd   = cmd;

endmodule

[hdl/rwcc_queue.sv]
// Short queue between front and back so either side can stall on its own.
// Depends on rwcc_pkg.

module rwcc_queue #(
  parameter int Depth = rwcc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  rwcc_pkg::cmd_xfer_t push,
  output logic                push_ready,
  output rwcc_pkg::cmd_xfer_t pop,
  input  logic                pop_ready
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rwcc_pkg::leg_cmd_t entries [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop.valid && pop_ready;
  assign pop.valid  = (count != '0);
  assign pop.cmd    = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

endmodule

[hdl/rwcc_back.sv]
// Back stage: runs the route state (clock, sums, window flag), holds the
// capacity registers and registers each result. Depends on rwcc_pkg and rwcc_if.

module rwcc_back (
  input  logic                clk,
  input  logic                rst,
  input  rwcc_pkg::cmd_xfer_t pop,
  output logic                pop_ready,
  rwcc_cfg_if.sink            cfg,
  rwcc_res_if.source          result
);

  localparam int TimeW = rwcc_pkg::TIME_W;
  localparam int SumW  = rwcc_pkg::SUM_W;
  localparam int CapW  = rwcc_pkg::CAP_W;

  logic [CapW-1:0]   weight_capacity;
  logic [CapW-1:0]   volume_capacity;

  logic [TimeW-1:0]  clock_time;
  logic [SumW-1:0]   distance_sum;
  logic [SumW-1:0]   travel_sum;
  logic [CapW-1:0]   weight_sum;
  logic [CapW-1:0]   volume_sum;
  logic              window_failed;

  logic              res_valid;
  rwcc_pkg::result_t res;
  rwcc_pkg::result_t res_next;

  logic [SumW:0]     dist_add;
  logic [SumW:0]     travel_add;
  logic [TimeW:0]    time_add;
  logic [CapW:0]     weight_add;
  logic [CapW:0]     volume_add;
  logic [SumW-1:0]   distance_sum_next;
  logic [SumW-1:0]   travel_sum_next;
  logic [TimeW-1:0]  time_adv;
  logic [TimeW-1:0]  clock_time_next;
  logic [CapW-1:0]   weight_sum_next;
  logic [CapW-1:0]   volume_sum_next;
  logic              window_failed_next;
  logic              cap_ok;
  logic              do_pop;

  // Capacity registers; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_capacity <= '0;
      volume_capacity <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        rwcc_pkg::CFG_WEIGHT_CAP: weight_capacity <= CapW'(cfg.data);
        rwcc_pkg::CFG_VOLUME_CAP: volume_capacity <= CapW'(cfg.data);
        default: ;
      endcase
    end
  end

  // Pop when the output register is free or being taken
  assign pop_ready = !res_valid || result.ready;
  assign do_pop    = pop.valid && pop_ready;

  // Saturating sums
  always_comb begin
    dist_add   = {1'b0, distance_sum} + (SumW+1)'(pop.cmd.leg_distance);
    travel_add = {1'b0, travel_sum} + (SumW+1)'(pop.cmd.leg_seconds);
    time_add   = {1'b0, clock_time} + (TimeW+1)'(pop.cmd.leg_seconds);
    weight_add = {1'b0, weight_sum} + (CapW+1)'(pop.cmd.parcel_weight);
    volume_add = {1'b0, volume_sum} + (CapW+1)'(pop.cmd.parcel_volume);

    distance_sum_next = dist_add[SumW]     ? '1 : dist_add[SumW-1:0];
    travel_sum_next   = travel_add[SumW]   ? '1 : travel_add[SumW-1:0];
    time_adv          = time_add[TimeW]    ? '1 : time_add[TimeW-1:0];
    weight_sum_next   = weight_add[CapW]   ? '1 : weight_add[CapW-1:0];
    volume_sum_next   = volume_add[CapW]   ? '1 : volume_add[CapW-1:0];
  end

  // Wait for the window start, then flag a late arrival
  always_comb begin
    clock_time_next    = (time_adv < pop.cmd.window_start) ? pop.cmd.window_start : time_adv;
    window_failed_next = window_failed || (clock_time_next > pop.cmd.window_end);
    cap_ok = (weight_sum_next <= weight_capacity) && (volume_sum_next <= volume_capacity);
  end

  // Build the result
  always_comb begin
    res_next.stop_time      = clock_time_next;
    res_next.route_done     = pop.cmd.is_return;
    res_next.feasible       = pop.cmd.is_return && cap_ok && !window_failed_next;
    res_next.capacity_ok    = pop.cmd.is_return && cap_ok;
    res_next.windows_ok     = !window_failed_next;
    res_next.total_distance = distance_sum_next;
    res_next.total_seconds  = travel_sum_next;
    res_next.weight_total   = weight_sum_next;
    res_next.volume_total   = volume_sum_next;
  end

  // Advance route state; a return leg clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_time    <= '0;
      distance_sum  <= '0;
      travel_sum    <= '0;
      weight_sum    <= '0;
      volume_sum    <= '0;
      window_failed <= 1'b0;
    end else if (do_pop) begin
      if (pop.cmd.is_return) begin
        clock_time    <= '0;
        distance_sum  <= '0;
        travel_sum    <= '0;
        weight_sum    <= '0;
        volume_sum    <= '0;
        window_failed <= 1'b0;
      end else begin
        clock_time    <= clock_time_next;
        distance_sum  <= distance_sum_next;
        travel_sum    <= travel_sum_next;
        weight_sum    <= weight_sum_next;
        volume_sum    <= volume_sum_next;
        window_failed <= window_failed_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_pop) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      res <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.stop_time      = res.stop_time;
  assign result.route_done     = res.route_done;
  assign result.feasible       = res.feasible;
  assign result.capacity_ok    = res.capacity_ok;
  assign result.windows_ok     = res.windows_ok;
  assign result.total_distance = res.total_distance;
  assign result.total_seconds  = res.total_seconds;
  assign result.weight_total   = res.weight_total;
  assign result.volume_total   = res.volume_total;

  // A return leg leaves a clean route behind it
  a_clear_after_return: assert property (@(posedge clk) disable iff (rst)
    do_pop && pop.cmd.is_return |=>
      clock_time == '0 && distance_sum == '0 && weight_sum == '0 && !window_failed)
    else $error("route state not cleared after return leg");

  // The feasible and capacity verdict bits only appear on the end of a route
  a_verdict_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.route_done |-> !res.feasible && !res.capacity_ok)
    else $error("verdict bits set on a delivery leg result");

  // Feasible means both checks passed
  a_feasible_parts: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.feasible |-> res.capacity_ok && res.windows_ok)
    else $error("feasible without capacity and windows");

  // A latched violation persists until the route ends
  a_window_sticky: assert property (@(posedge clk) disable iff (rst)
    window_failed && !(do_pop && pop.cmd.is_return) |=> window_failed)
    else $error("window violation dropped mid-route");

endmodule

[hdl/route_window_capacity_check_top.sv]
// Top level of the route window and capacity checker: front, queue and back.
// Depends on rwcc_pkg, rwcc_if, rwcc_front, rwcc_queue and rwcc_back.
//
//   Channel  Kind       Carries
//   leg      sink       one route leg per transfer
//   result   source     one result per leg, in order
//   cfg      sink       capacity register write (index, data), always ready
//
// One leg per cycle sustained while results are taken; a leg's result passes in turn
// through the three registers on the path (front register, queue slot, output
// register) before it is valid on the result channel.
// Synchronous reset clears capacities, route state and all valid flags.
// A stalled result holds the back stage; the queue then fills and the front
// stops taking legs only when both are full.

module route_window_capacity_check_top #(
  parameter int QueueDepth = rwcc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  rwcc_leg_if.sink   leg,
  rwcc_res_if.source result,
  rwcc_cfg_if.sink   cfg
);

  rwcc_pkg::cmd_xfer_t push;
  rwcc_pkg::cmd_xfer_t pop;
  logic                push_ready;
  logic                pop_ready;

  rwcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .leg        (leg),
    .push       (push),
    .push_ready (push_ready)
  );

  rwcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_ready  (pop_ready)
  );

  rwcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_ready (pop_ready),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
